/* rtl/core/pcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

    // Number of polygon vertices held so far; saturates at two.
    typedef enum logic [1:0] {
        SEEN_NONE = 2'd0,
        SEEN_ONE  = 2'd1,
        SEEN_TWO  = 2'd2
    } t_seen;

endpackage

`default_nettype wire

/* rtl/core/polygon_convexity_check_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Polygon convexity check, one vertex per input transaction.
// Input channel: i_valid / o_ready carry i_vx, i_vy (signed, COORD_BITS) and
// i_last, which marks the final vertex of a polygon. The next transaction
// starts a new polygon.
// Output channel: o_valid / i_ready carry o_convex. There is exactly one result
// per polygon, produced by the vertex with i_last set.
// Rate: one vertex per cycle while o_ready is high. Each turn is computed in the
// cycle in which its vertex is accepted. Two multipliers per turn, and three turns
// in parallel, close the polygon on its last vertex.
// The result is registered in the output register, or in the skid entry if that is held.
// Stall: results go into a two-entry output buffer. Vertices keep flowing while
// one result waits. o_ready drops only while both entries are full.
// Reset (synchronous, active low): clears the polygon state and empties the
// output buffer.
module polygon_convexity_check_top
    import pcc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire signed [COORD_BITS-1:0] i_vx,
    input  wire signed [COORD_BITS-1:0] i_vy,
    input  wire                         i_last,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic                        o_convex
);

    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS + 1;
    localparam int MW = 2 * EW;
    localparam int PW = 2 * COORD_BITS + 3;

    // Sign of the cross product of edges a->b and b->c, strictly positive.
    function automatic logic turn_pos(
        input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
        input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
        input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy
    );
        logic signed [EW-1:0] ux, uy, wx, wy;
        logic signed [MW-1:0] p1, p2;
        logic signed [PW-1:0] prod;
        ux   = {bx[CW-1], bx} - {ax[CW-1], ax};
        uy   = {by[CW-1], by} - {ay[CW-1], ay};
        wx   = {cx[CW-1], cx} - {bx[CW-1], bx};
        wy   = {cy[CW-1], cy} - {by[CW-1], by};
        p1   = ux * wy;
        p2   = uy * wx;
        prod = {p1[MW-1], p1} - {p2[MW-1], p2};
        return !prod[PW-1] && (|prod);
    endfunction

    logic signed [CW-1:0] r_first_x, r_first_y, r_second_x, r_second_y;
    logic signed [CW-1:0] r_older_x, r_older_y, r_prior_x, r_prior_y;
    t_seen                r_seen;
    logic                 r_saw_pos, r_saw_nonpos;

    logic r_out_valid, r_out_convex;
    logic r_skid_valid, r_skid_convex;

    logic accept, pop, produce;
    logic t_in, t_close0, t_close1;
    logic any_pos, any_nonpos, n_convex;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_convex = r_out_convex;

    assign accept  = i_valid && o_ready;
    assign pop     = r_out_valid && i_ready;
    assign produce = accept && i_last;

    // Turn at the prior vertex, then the two wrap-around turns on close.
    assign t_in     = turn_pos(r_older_x, r_older_y, r_prior_x, r_prior_y, i_vx, i_vy);
    assign t_close0 = turn_pos(r_prior_x, r_prior_y, i_vx, i_vy, r_first_x, r_first_y);
    assign t_close1 = turn_pos(i_vx, i_vy, r_first_x, r_first_y, r_second_x, r_second_y);

    always_comb begin
        any_pos    = r_saw_pos || t_in || t_close0 || t_close1;
        any_nonpos = r_saw_nonpos || !t_in || !t_close0 || !t_close1;
        n_convex   = (r_seen == SEEN_TWO) ? !(any_pos && any_nonpos) : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x    <= '0;
            r_first_y    <= '0;
            r_second_x   <= '0;
            r_second_y   <= '0;
            r_older_x    <= '0;
            r_older_y    <= '0;
            r_prior_x    <= '0;
            r_prior_y    <= '0;
            r_seen       <= SEEN_NONE;
            r_saw_pos    <= 1'b0;
            r_saw_nonpos <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_first_x    <= '0;
                r_first_y    <= '0;
                r_second_x   <= '0;
                r_second_y   <= '0;
                r_older_x    <= '0;
                r_older_y    <= '0;
                r_prior_x    <= '0;
                r_prior_y    <= '0;
                r_seen       <= SEEN_NONE;
                r_saw_pos    <= 1'b0;
                r_saw_nonpos <= 1'b0;
            end else begin
                case (r_seen)
                    SEEN_NONE: begin
                        r_first_x <= i_vx;
                        r_first_y <= i_vy;
                        r_seen    <= SEEN_ONE;
                    end
                    SEEN_ONE: begin
                        r_second_x <= i_vx;
                        r_second_y <= i_vy;
                        r_seen     <= SEEN_TWO;
                    end
                    default: begin
                        if (t_in) begin
                            r_saw_pos <= 1'b1;
                        end else begin
                            r_saw_nonpos <= 1'b1;
                        end
                    end
                endcase
                r_older_x <= r_prior_x;
                r_older_y <= r_prior_y;
                r_prior_x <= i_vx;
                r_prior_y <= i_vy;
            end
        end
    end

    // Two-entry result buffer: output register plus skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_convex <= r_skid_convex;
                r_skid_valid <= 1'b0;
            end
        end else if (produce) begin
            if (!r_out_valid || pop) begin
                r_out_valid  <= 1'b1;
                r_out_convex <= n_convex;
            end else begin
                r_skid_valid  <= 1'b1;
                r_skid_convex <= n_convex;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_short_is_convex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && r_seen != SEEN_TWO && !r_out_valid) |=> (o_valid && o_convex))
        else $error("polygon of one or two vertices not reported convex");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> (r_seen == SEEN_NONE && !r_saw_pos && !r_saw_nonpos))
        else $error("polygon state not cleared after last vertex");

    a_result_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |=> o_valid)
        else $error("result lost after last vertex");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("output buffer not empty after reset");

endmodule

`default_nettype wire
